[rtl/text_terminal_byte_interpreter_assert.svh]
// Assertion macros for the text terminal byte interpreter checker.
// Depends on nothing; included by the checker file.
`ifndef TEXT_TERMINAL_BYTE_INTERPRETER_ASSERT_SVH
`define TEXT_TERMINAL_BYTE_INTERPRETER_ASSERT_SVH

// Clocked assertion that is switched off while reset is high.
`define TTBI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define TTBI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ttbi_pkg.sv]
// Shared constants, byte codes and controller/datapath interface types
// for the text terminal byte interpreter. Depends on nothing.
package ttbi_pkg;

   localparam int COLUMNS    = 32;
   localparam int ROWS       = 16;
   localparam int COL_W      = $clog2(COLUMNS);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int TAB_WRITES = 3;
   localparam int TAB_CNT_W  = $clog2(TAB_WRITES);

   // Control bytes in normal phase.
   localparam logic [7:0] CH_NUL        = 8'h00;
   localparam logic [7:0] CH_BEL        = 8'h07;
   localparam logic [7:0] CH_BS         = 8'h08;
   localparam logic [7:0] CH_TAB        = 8'h09;
   localparam logic [7:0] CH_LF         = 8'h0A;
   localparam logic [7:0] CH_UP         = 8'h0B;
   localparam logic [7:0] CH_CR         = 8'h0D;
   localparam logic [7:0] CH_DOWN       = 8'h16;
   localparam logic [7:0] CH_CLEAR      = 8'h1A;
   localparam logic [7:0] CH_ESC        = 8'h1B;
   localparam logic [7:0] CH_HOME       = 8'h1E;
   localparam logic [7:0] CH_ADVANCE    = 8'h1F;
   localparam logic [7:0] CH_CODE_BASE  = 8'h20;

   // Bytes after ESC.
   localparam logic [7:0] CH_ESC_HOME   = 8'h7D;
   localparam logic [7:0] CH_CLR_STAR   = 8'h2A;
   localparam logic [7:0] CH_CLR_COMMA  = 8'h2C;
   localparam logic [7:0] CH_CLR_COLON  = 8'h3A;
   localparam logic [7:0] CH_CLR_SEMI   = 8'h3B;
   localparam logic [7:0] CH_CLR_PLUS   = 8'h2B;
   localparam logic [7:0] CH_APOSTROPHE = 8'h27;
   localparam logic [7:0] CH_ERASE_EOL  = 8'h54;

   // Bytes after ESC apostrophe.
   localparam logic [7:0] CH_CURSOR_OFF = 8'h30;
   localparam logic [7:0] CH_CURSOR_ON  = 8'h31;

   typedef enum logic [1:0] {
      OP_BYTE,
      OP_TAB,
      OP_ERASE
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
      logic   last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic byte_nonzero;
      logic is_tab;
      logic is_erase;
      logic col_at_end;
      logic erase_done;
   } status_type;

endpackage

[rtl/ttbi_dpath.sv]
// Datapath of the text terminal byte interpreter: cursor and escape state,
// byte decode and the result register. Depends on ttbi_pkg.
module ttbi_dpath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [7:0]           req_char_code,
   input  ttbi_pkg::cmd_type    cmd,
   output ttbi_pkg::status_type status,
   input  logic                 rsp_stall,
   output logic                 rsp_valid,
   output logic                 rsp_write_valid,
   output logic [8:0]           rsp_write_addr,
   output logic [7:0]           rsp_write_code,
   output logic                 rsp_clear_screen,
   output logic                 rsp_scroll_up,
   output logic                 rsp_beep,
   output logic [4:0]           rsp_cursor_col,
   output logic [3:0]           rsp_cursor_row,
   output logic                 rsp_cursor_shown,
   output logic                 rsp_last
);
   import ttbi_pkg::*;

   localparam logic [1:0] PH_NORMAL = 2'd0;
   localparam logic [1:0] PH_ESC    = 2'd1;
   localparam logic [1:0] PH_CURSOR = 2'd2;

   localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);
   localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(ROWS - 1);

   logic [COL_W-1:0] column_ff, column_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [1:0]       phase_ff, phase_in;
   logic             cursor_ff, cursor_in;
   logic [COL_W-1:0] erase_col_ff, erase_col_in;

   logic             valid_ff, valid_in;
   logic             wv_ff, wv_in;
   logic [8:0]       addr_ff, addr_in;
   logic [7:0]       code_ff, code_in;
   logic             clear_ff, clear_in;
   logic             scroll_ff, scroll_in;
   logic             beep_ff, beep_in;
   logic [4:0]       ccol_ff, ccol_in;
   logic [3:0]       crow_ff, crow_in;
   logic             shown_ff, shown_in;
   logic             last_ff, last_in;

   logic [COL_W-1:0] wr_col;
   logic [ROW_W-1:0] wr_row;
   logic [COL_W-1:0] adv_col;
   logic [ROW_W-1:0] adv_row;
   logic             adv_scroll;
   logic             esc_phase;
   logic             cur_phase;

   // Cursor advance with wrap into the next row and scroll at the bottom.
   always_comb begin
      adv_scroll = 1'b0;
      adv_row    = row_ff;
      if (column_ff == COL_LAST) begin
         adv_col = '0;
         if (row_ff == ROW_LAST) begin
            adv_scroll = 1'b1;
         end else begin
            adv_row = row_ff + 1'b1;
         end
      end else begin
         adv_col = column_ff + 1'b1;
      end
   end

   assign esc_phase = (phase_ff == PH_ESC);
   assign cur_phase = (phase_ff == PH_CURSOR);

   assign status.out_free     = !valid_ff || !rsp_stall;
   assign status.byte_nonzero = (req_char_code != CH_NUL);
   assign status.is_tab       = !esc_phase && !cur_phase && (req_char_code == CH_TAB);
   assign status.is_erase     = esc_phase && (req_char_code == CH_ERASE_EOL);
   assign status.col_at_end   = (column_ff == COL_LAST);
   assign status.erase_done   = (erase_col_ff == COL_LAST);

   always_comb begin
      column_in    = column_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      cursor_in    = cursor_ff;
      erase_col_in = erase_col_ff;
      wv_in        = 1'b0;
      wr_col       = column_ff;
      wr_row       = row_ff;
      code_in      = '0;
      clear_in     = 1'b0;
      scroll_in    = 1'b0;
      beep_in      = 1'b0;
      unique case (cmd.op)
         OP_BYTE: begin
            phase_in = PH_NORMAL;
            if (esc_phase) begin
               if (req_char_code == CH_ESC_HOME) begin
                  column_in = '0;
                  row_in    = '0;
               end else if (req_char_code == CH_CLR_STAR || req_char_code == CH_CLR_COMMA
                            || req_char_code == CH_CLR_COLON
                            || req_char_code == CH_CLR_SEMI
                            || req_char_code == CH_CLR_PLUS) begin
                  column_in = '0;
                  row_in    = '0;
                  clear_in  = 1'b1;
               end else if (req_char_code == CH_APOSTROPHE) begin
                  phase_in = PH_CURSOR;
               end else if (req_char_code == CH_ERASE_EOL) begin
                  wv_in        = 1'b1;
                  erase_col_in = column_ff + 1'b1;
               end
            end else if (cur_phase) begin
               if (req_char_code == CH_CURSOR_OFF) begin
                  cursor_in = 1'b0;
               end else if (req_char_code == CH_CURSOR_ON) begin
                  cursor_in = 1'b1;
               end
            end else begin
               unique case (req_char_code)
                  CH_BEL: begin
                     beep_in = 1'b1;
                  end
                  CH_BS: begin
                     if (column_ff != '0) begin
                        column_in = column_ff - 1'b1;
                     end
                  end
                  CH_TAB: begin
                     wv_in     = 1'b1;
                     column_in = adv_col;
                     row_in    = adv_row;
                     scroll_in = adv_scroll;
                  end
                  CH_LF: begin
                     if (row_ff == ROW_LAST) begin
                        scroll_in = 1'b1;
                     end else begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  CH_UP: begin
                     row_in = (row_ff == '0) ? ROW_LAST : row_ff - 1'b1;
                  end
                  CH_CR: begin
                     column_in = '0;
                  end
                  CH_DOWN: begin
                     if (row_ff != ROW_LAST) begin
                        row_in = row_ff + 1'b1;
                     end
                  end
                  CH_CLEAR: begin
                     column_in = '0;
                     row_in    = '0;
                     clear_in  = 1'b1;
                  end
                  CH_ESC: begin
                     phase_in = PH_ESC;
                  end
                  CH_HOME: begin
                     column_in = '0;
                     row_in    = '0;
                  end
                  CH_ADVANCE: begin
                     column_in = adv_col;
                     row_in    = adv_row;
                     scroll_in = adv_scroll;
                  end
                  default: begin
                     wv_in     = 1'b1;
                     code_in   = req_char_code - CH_CODE_BASE;
                     column_in = adv_col;
                     row_in    = adv_row;
                     scroll_in = adv_scroll;
                  end
               endcase
            end
         end
         OP_TAB: begin
            wv_in     = 1'b1;
            column_in = adv_col;
            row_in    = adv_row;
            scroll_in = adv_scroll;
         end
         OP_ERASE: begin
            wv_in        = 1'b1;
            wr_col       = erase_col_ff;
            erase_col_in = erase_col_ff + 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign addr_in  = wv_in ? 9'(wr_row * COLUMNS + wr_col) : '0;
   assign ccol_in  = 5'(column_in);
   assign crow_in  = 4'(row_in);
   assign shown_in = cursor_in;
   assign last_in  = cmd.last;
   assign valid_in = cmd.load || (valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff <= '0;
         row_ff    <= '0;
         phase_ff  <= PH_NORMAL;
         cursor_ff <= 1'b1;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (cmd.load) begin
            column_ff <= column_in;
            row_ff    <= row_in;
            phase_ff  <= phase_in;
            cursor_ff <= cursor_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         erase_col_ff <= erase_col_in;
         wv_ff        <= wv_in;
         addr_ff      <= addr_in;
         code_ff      <= code_in;
         clear_ff     <= clear_in;
         scroll_ff    <= scroll_in;
         beep_ff      <= beep_in;
         ccol_ff      <= ccol_in;
         crow_ff      <= crow_in;
         shown_ff     <= shown_in;
         last_ff      <= last_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_write_valid  = wv_ff;
   assign rsp_write_addr   = addr_ff;
   assign rsp_write_code   = code_ff;
   assign rsp_clear_screen = clear_ff;
   assign rsp_scroll_up    = scroll_ff;
   assign rsp_beep         = beep_ff;
   assign rsp_cursor_col   = ccol_ff;
   assign rsp_cursor_row   = crow_ff;
   assign rsp_cursor_shown = shown_ff;
   assign rsp_last         = last_ff;

endmodule

[rtl/ttbi_ctrl.sv]
// Controller of the text terminal byte interpreter: sequences the tab and
// erase-to-end-of-line bursts. Depends on ttbi_pkg.
module ttbi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ttbi_pkg::status_type status,
   output ttbi_pkg::cmd_type    cmd
);
   import ttbi_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_TAB   = 2'd1;
   localparam logic [1:0] S_ERASE = 2'd2;

   logic [1:0]           state_ff, state_in;
   logic [TAB_CNT_W-1:0] tab_cnt_ff, tab_cnt_in;

   always_comb begin
      state_in   = state_ff;
      tab_cnt_in = tab_cnt_ff;
      req_stall  = 1'b1;
      cmd.load   = 1'b0;
      cmd.op     = OP_BYTE;
      cmd.last   = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            req_stall = !status.out_free;
            if (req_valid && status.out_free && status.byte_nonzero) begin
               cmd.load = 1'b1;
               if (status.is_tab) begin
                  cmd.last   = 1'b0;
                  state_in   = S_TAB;
                  tab_cnt_in = TAB_CNT_W'(TAB_WRITES - 1);
               end else if (status.is_erase && !status.col_at_end) begin
                  cmd.last = 1'b0;
                  state_in = S_ERASE;
               end
            end
         end
         S_TAB: begin
            if (status.out_free) begin
               cmd.load   = 1'b1;
               cmd.op     = OP_TAB;
               cmd.last   = (tab_cnt_ff == TAB_CNT_W'(1));
               tab_cnt_in = tab_cnt_ff - 1'b1;
               if (cmd.last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERASE: begin
            if (status.out_free) begin
               cmd.load = 1'b1;
               cmd.op   = OP_ERASE;
               cmd.last = status.erase_done;
               if (status.erase_done) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         tab_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         tab_cnt_ff <= tab_cnt_in;
      end
   end

endmodule

[rtl/text_terminal_byte_interpreter.sv]
// Text terminal byte interpreter: a byte's first result appears in the cycle after
// its transfer; a single-result byte sustains one byte per cycle while unstalled.
// A tab gives three results and ESC T up to 32, one per cycle while unstalled,
// and the input is stalled until the last result of the burst is registered.
// Synchronous reset homes the cursor, shows it, leaves escape mode and empties
// the result register. Depends on ttbi_pkg, ttbi_ctrl and ttbi_dpath.
module text_terminal_byte_interpreter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_char_code,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_write_valid,
   output logic [8:0] rsp_write_addr,
   output logic [7:0] rsp_write_code,
   output logic       rsp_clear_screen,
   output logic       rsp_scroll_up,
   output logic       rsp_beep,
   output logic [4:0] rsp_cursor_col,
   output logic [3:0] rsp_cursor_row,
   output logic       rsp_cursor_shown,
   output logic       rsp_last
);
   import ttbi_pkg::*;

   // The controller only decides when the datapath loads its result register,
   // which kind of step it performs and whether it is the last. All cursor and
   // escape state lives in the datapath, which reports back the few decode facts
   // the controller needs to start and finish a burst.
   cmd_type    cmd;
   status_type status;

   // The controller accepts a new byte in the same cycle that the previous
   // result is taken, so the result register acts as the only buffer between
   // the two channels. A zero byte is transferred but produces no result.
   ttbi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath updates the cursor state only when a result is loaded, so
   // each result carries the cursor position as it stands after that step.
   ttbi_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_char_code    (req_char_code),
      .cmd              (cmd),
      .status           (status),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_write_code   (rsp_write_code),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_scroll_up    (rsp_scroll_up),
      .rsp_beep         (rsp_beep),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_shown (rsp_cursor_shown),
      .rsp_last         (rsp_last)
   );

endmodule

[rtl/ttbi_checker.sv]
// Port-level checker for the text terminal byte interpreter, bound to the
// top level. Depends on ttbi_pkg and text_terminal_byte_interpreter_assert.svh.
`include "text_terminal_byte_interpreter_assert.svh"

module ttbi_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic       rsp_write_valid,
   input logic [8:0] rsp_write_addr,
   input logic [7:0] rsp_write_code,
   input logic       rsp_scroll_up,
   input logic [3:0] rsp_cursor_row,
   input logic       rsp_last
);
   import ttbi_pkg::*;

   // A stalled result keeps its address and last flag.
   `TTBI_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_write_addr) && $stable(rsp_last),
      "stalled result changed")

   // A result without a write carries zero address and code.
   `TTBI_ASSERT(a_idle_write_zero, clock, reset,
      rsp_valid && !rsp_write_valid |-> rsp_write_addr == '0 && rsp_write_code == '0,
      "write fields set without a write")

   // Only tab and erase bursts give more than one result, and all are blanks.
   `TTBI_ASSERT(a_burst_blank, clock, reset,
      rsp_valid && !rsp_last |-> rsp_write_valid && rsp_write_code == '0,
      "non-final result is not a blank write")

   // Scrolling only happens with the cursor on the bottom row.
   `TTBI_ASSERT(a_scroll_bottom, clock, reset,
      rsp_valid && rsp_scroll_up |-> rsp_cursor_row == 4'(ROWS - 1),
      "scroll away from the bottom row")

   // Reset empties the result register.
   `TTBI_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_valid, "result pending after reset")

endmodule

bind text_terminal_byte_interpreter ttbi_checker u_ttbi_checker (.*);

[dv/screen_update_checker.sv]
`timescale 1ns / 1ps
// Checker for the text terminal byte interpreter: tracks cursor and escape state,
// predicts screen updates per accepted byte, compares results. Depends on ttbi_pkg.
module screen_update_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_char_code,
   input  logic       rsp_valid,
   input  logic       rsp_stall,
   input  logic       rsp_write_valid,
   input  logic [8:0] rsp_write_addr,
   input  logic [7:0] rsp_write_code,
   input  logic       rsp_clear_screen,
   input  logic       rsp_scroll_up,
   input  logic       rsp_beep,
   input  logic [4:0] rsp_cursor_col,
   input  logic [3:0] rsp_cursor_row,
   input  logic       rsp_cursor_shown,
   input  logic       rsp_last,
   output int         failures,
   output int         outstanding
);
   import ttbi_pkg::*;

   typedef enum logic [1:0] {
      ESC_NONE,
      ESC_OPEN,
      ESC_CURSOR
   } esc_phase_type;

   typedef struct packed {
      logic       write_valid;
      logic [8:0] write_addr;
      logic [7:0] write_code;
      logic       clear_screen;
      logic       scroll_up;
      logic       beep;
      logic [4:0] col;
      logic [3:0] row;
      logic       shown;
      logic       last;
   } screen_update_type;

   logic [COL_W-1:0]  cur_col;
   logic [ROW_W-1:0]  cur_row;
   logic              cur_shown;
   esc_phase_type     esc_phase;
   screen_update_type pending_updates[$];

   function automatic logic [8:0] cell_addr(input int col);
      return 9'(int'(cur_row) * COLUMNS + col);
   endfunction

   // Returns 1 when moving down runs off the bottom and the screen scrolls.
   function automatic logic step_row();
      if (int'(cur_row) == ROWS - 1) return 1'b1;
      cur_row = cur_row + 1'b1;
      return 1'b0;
   endfunction

   function automatic logic step_col();
      if (int'(cur_col) == COLUMNS - 1) begin
         cur_col = '0;
         return step_row();
      end
      cur_col = cur_col + 1'b1;
      return 1'b0;
   endfunction

   task automatic queue_update(input logic wv, input logic [8:0] addr, input logic [7:0] code,
                               input logic clr, input logic scr, input logic bp);
      screen_update_type u;
      u.write_valid  = wv;
      u.write_addr   = wv ? addr : '0;
      u.write_code   = wv ? code : '0;
      u.clear_screen = clr;
      u.scroll_up    = scr;
      u.beep         = bp;
      u.col          = cur_col;
      u.row          = cur_row;
      u.shown        = cur_shown;
      u.last         = 1'b0;
      pending_updates.push_back(u);
   endtask

   task automatic predict_screen_updates(input logic [7:0] b);
      logic [8:0]        addr;
      logic              scr;
      screen_update_type tail;
      if (b == CH_NUL) return;
      case (esc_phase)
         ESC_OPEN: begin
            esc_phase = ESC_NONE;
            if (b == CH_ESC_HOME) begin
               cur_col = '0;
               cur_row = '0;
               queue_update(0, 0, 0, 0, 0, 0);
            end else if (b == CH_CLR_STAR || b == CH_CLR_COMMA || b == CH_CLR_COLON ||
                         b == CH_CLR_SEMI || b == CH_CLR_PLUS) begin
               cur_col = '0;
               cur_row = '0;
               queue_update(0, 0, 0, 1, 0, 0);
            end else if (b == CH_APOSTROPHE) begin
               esc_phase = ESC_CURSOR;
               queue_update(0, 0, 0, 0, 0, 0);
            end else if (b == CH_ERASE_EOL) begin
               for (int x = int'(cur_col); x < COLUMNS; x++)
                  queue_update(1, cell_addr(x), 0, 0, 0, 0);
            end else begin
               queue_update(0, 0, 0, 0, 0, 0);
            end
         end
         ESC_CURSOR: begin
            esc_phase = ESC_NONE;
            if (b == CH_CURSOR_OFF) cur_shown = 1'b0;
            else if (b == CH_CURSOR_ON) cur_shown = 1'b1;
            queue_update(0, 0, 0, 0, 0, 0);
         end
         default: begin
            esc_phase = ESC_NONE;
            case (b)
               CH_BEL: queue_update(0, 0, 0, 0, 0, 1);
               CH_BS: begin
                  if (cur_col != '0) cur_col = cur_col - 1'b1;
                  queue_update(0, 0, 0, 0, 0, 0);
               end
               CH_TAB: begin
                  for (int i = 0; i < TAB_WRITES; i++) begin
                     addr = cell_addr(int'(cur_col));
                     scr  = step_col();
                     queue_update(1, addr, 0, 0, scr, 0);
                  end
               end
               CH_LF: begin
                  scr = step_row();
                  queue_update(0, 0, 0, 0, scr, 0);
               end
               CH_UP: begin
                  cur_row = (cur_row == '0) ? ROW_W'(ROWS - 1) : cur_row - 1'b1;
                  queue_update(0, 0, 0, 0, 0, 0);
               end
               CH_CR: begin
                  cur_col = '0;
                  queue_update(0, 0, 0, 0, 0, 0);
               end
               CH_DOWN: begin
                  if (int'(cur_row) < ROWS - 1) cur_row = cur_row + 1'b1;
                  queue_update(0, 0, 0, 0, 0, 0);
               end
               CH_CLEAR: begin
                  cur_col = '0;
                  cur_row = '0;
                  queue_update(0, 0, 0, 1, 0, 0);
               end
               CH_ESC: begin
                  esc_phase = ESC_OPEN;
                  queue_update(0, 0, 0, 0, 0, 0);
               end
               CH_HOME: begin
                  cur_col = '0;
                  cur_row = '0;
                  queue_update(0, 0, 0, 0, 0, 0);
               end
               CH_ADVANCE: begin
                  scr = step_col();
                  queue_update(0, 0, 0, 0, scr, 0);
               end
               default: begin
                  addr = cell_addr(int'(cur_col));
                  scr  = step_col();
                  queue_update(1, addr, b - CH_CODE_BASE, 0, scr, 0);
               end
            endcase
         end
      endcase
      // The final update of every byte carries the last flag.
      tail = pending_updates.pop_back();
      tail.last = 1'b1;
      pending_updates.push_back(tail);
   endtask

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0h, got %0h", name, exp_v, act_v);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      screen_update_type want;
      if (reset) begin
         cur_col   = '0;
         cur_row   = '0;
         cur_shown = 1'b1;
         esc_phase = ESC_NONE;
         pending_updates.delete();
      end else begin
         if (req_valid && !req_stall) predict_screen_updates(req_char_code);
         if (rsp_valid && !rsp_stall) begin
            if (pending_updates.size() == 0) begin
               $error("result transfer with no update pending");
               failures++;
            end else begin
               want = pending_updates.pop_front();
               check_field("write_valid", want.write_valid, rsp_write_valid);
               check_field("write_addr", want.write_addr, rsp_write_addr);
               check_field("write_code", want.write_code, rsp_write_code);
               check_field("clear_screen", want.clear_screen, rsp_clear_screen);
               check_field("scroll_up", want.scroll_up, rsp_scroll_up);
               check_field("beep", want.beep, rsp_beep);
               check_field("cursor_col", want.col, rsp_cursor_col);
               check_field("cursor_row", want.row, rsp_cursor_row);
               check_field("cursor_shown", want.shown, rsp_cursor_shown);
               check_field("last", want.last, rsp_last);
            end
         end
      end
      outstanding = pending_updates.size();
   end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Top of the text terminal byte interpreter testbench: clock, reset, byte stimulus,
// result back-pressure and the verdict. Depends on ttbi_pkg and screen_update_checker.
module testbench;
   import ttbi_pkg::*;

   // Longest stretch without any transfer before the run is declared hung. The
   // deliberate result hold-off below is far shorter than this.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int HOLD_CYCLES    = 300;
   localparam int DRAIN_CYCLES   = 60;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [7:0] req_char_code = 8'h00;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_write_valid;
   logic [8:0] rsp_write_addr;
   logic [7:0] rsp_write_code;
   logic       rsp_clear_screen;
   logic       rsp_scroll_up;
   logic       rsp_beep;
   logic [4:0] rsp_cursor_col;
   logic [3:0] rsp_cursor_row;
   logic       rsp_cursor_shown;
   logic       rsp_last;

   int failures;
   int outstanding;
   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int quiet_cycles = 0;
   // Set by the stimulus to ask the result side for one long hold-off.
   logic hold_results = 1'b0;

   always #5 clock = ~clock;

   text_terminal_byte_interpreter u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_write_code   (rsp_write_code),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_scroll_up    (rsp_scroll_up),
      .rsp_beep         (rsp_beep),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_shown (rsp_cursor_shown),
      .rsp_last         (rsp_last)
   );

   screen_update_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_char_code    (req_char_code),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_write_valid  (rsp_write_valid),
      .rsp_write_addr   (rsp_write_addr),
      .rsp_write_code   (rsp_write_code),
      .rsp_clear_screen (rsp_clear_screen),
      .rsp_scroll_up    (rsp_scroll_up),
      .rsp_beep         (rsp_beep),
      .rsp_cursor_col   (rsp_cursor_col),
      .rsp_cursor_row   (rsp_cursor_row),
      .rsp_cursor_shown (rsp_cursor_shown),
      .rsp_last         (rsp_last),
      .failures         (failures),
      .outstanding      (outstanding)
   );

   // Offers one byte and returns at the falling edge after its transfer. Idle
   // cycles are inserted first, with a scrambled payload so that nothing relies
   // on the data while valid is low. Valid stays high between back-to-back bytes.
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid     <= 1'b0;
         req_char_code <= 8'($urandom);
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_char_code <= b;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Random traffic, mostly well-formed: runs of text that wrap and scroll,
   // cursor control codes, and complete escape sequences with random tails.
   // About a tenth is raw noise, which also reaches the zero byte. Zero bytes
   // are ignored by the block and do not count toward n.
   task automatic send_random_items(input int n);
      int         sent;
      int         pick;
      int         len;
      logic [7:0] b;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 55) begin
            len = $urandom_range(1, 12);
            for (int i = 0; i < len; i++) begin
               if ($urandom_range(3) == 0) b = 8'($urandom_range(8'h80, 8'hFF));
               else b = 8'($urandom_range(CH_CODE_BASE, 8'h7E));
               send_byte(b);
            end
            sent += len;
         end else if (pick < 72) begin
            case ($urandom_range(10))
               0: b = CH_BEL;
               1: b = CH_BS;
               2: b = CH_TAB;
               3: b = CH_LF;
               4: b = CH_LF;
               5: b = CH_UP;
               6: b = CH_CR;
               7: b = CH_DOWN;
               8: b = CH_CLEAR;
               9: b = CH_HOME;
               default: b = CH_ADVANCE;
            endcase
            send_byte(b);
            sent++;
         end else if (pick < 90) begin
            send_byte(CH_ESC);
            case ($urandom_range(8))
               0: b = CH_ESC_HOME;
               1: b = CH_CLR_STAR;
               2: b = CH_CLR_COMMA;
               3: b = CH_CLR_COLON;
               4: b = CH_CLR_SEMI;
               5: b = CH_CLR_PLUS;
               6: b = CH_ERASE_EOL;
               7: b = CH_APOSTROPHE;
               default: b = 8'($urandom);
            endcase
            send_byte(b);
            sent += (b != CH_NUL) ? 2 : 1;
            if (b == CH_APOSTROPHE) begin
               case ($urandom_range(2))
                  0: b = CH_CURSOR_OFF;
                  1: b = CH_CURSOR_ON;
                  default: b = 8'($urandom);
               endcase
               send_byte(b);
               if (b != CH_NUL) sent++;
            end
         end else begin
            b = 8'($urandom_range(0, 255));
            send_byte(b);
            if (b != CH_NUL) sent++;
         end
      end
   endtask

   // Result side back-pressure. On request it holds stall high for a long
   // stretch, counted here, so that the block fills up and stalls its input
   // while the sender keeps offering bytes.
   initial begin
      forever begin
         @(negedge clock);
         if (hold_results) begin
            hold_results = 1'b0;
            rsp_stall   <= 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   // The watchdog restarts on every transfer on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Phase one: the sender idles now and then, the receiver most of the time.
      req_idle_pct = 15;
      rsp_idle_pct = 67;

      // Directed bytes. A zero byte first, then the lowest and highest text
      // bytes. Backspace three times reaches column zero and then stops there.
      // Cursor up from the top row wraps to the bottom, where cursor down is
      // held and line feed scrolls. A zero byte inside an escape leaves the
      // escape open, so the following T erases a whole bottom row. Then tab,
      // beep, advance, carriage return, an ordinary control byte written as a
      // cell, cursor off and on, escape home, escape clear, plain clear, home,
      // and an escape followed by a byte it ignores.
      send_byte(CH_NUL);
      send_byte(CH_CODE_BASE);
      send_byte(8'hFF);
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_byte(CH_BS);
      send_byte(CH_UP);
      send_byte(CH_DOWN);
      send_byte(CH_LF);
      send_byte(CH_ESC);
      send_byte(CH_NUL);
      send_byte(CH_ERASE_EOL);
      send_byte(CH_TAB);
      send_byte(CH_BEL);
      send_byte(CH_ADVANCE);
      send_byte(CH_CR);
      send_byte(8'h01);
      send_byte(CH_ESC);
      send_byte(CH_APOSTROPHE);
      send_byte(CH_CURSOR_OFF);
      send_byte(CH_ESC);
      send_byte(CH_APOSTROPHE);
      send_byte(CH_CURSOR_ON);
      send_byte(CH_ESC);
      send_byte(CH_ESC_HOME);
      send_byte(CH_ESC);
      send_byte(CH_CLR_STAR);
      send_byte(CH_CLEAR);
      send_byte(CH_HOME);
      send_byte(CH_ESC);
      send_byte(8'h61);

      send_random_items(130);

      // Phase two: the roles swap.
      req_idle_pct = 67;
      rsp_idle_pct = 15;
      send_random_items(130);

      // Phase three: no idling at all, apart from one long result hold-off.
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_results = 1'b1;
      send_random_items(120);
      req_valid <= 1'b0;

      // Let every predicted result arrive, then give the block time to show
      // any result that should not exist.
      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
